### sv/ipdc_pkg.sv
// Shared constants and types of the IR proximity delta calibrator.
`default_nettype none
package ipdc_pkg;

	// Default configuration of the top level.
	localparam int SENSOR_COUNT_DEF = 8;
	localparam int CAL_FRAMES_DEF   = 100;
	localparam int SAMPLE_BITS_DEF  = 12;

	// Field widths of the input and result beats.
	localparam int PAIR_W   = 2;
	localparam int SAMPLE_W = 12;
	localparam int DELTA_W  = 13;
	localparam int CAL_W    = 13;

	// Stored state widths.
	localparam int OFS_W   = 13;
	localparam int SUM_W   = 20;
	localparam int FRAME_W = 7;

	// At most four pairs are addressable by the pair index.
	localparam int MAX_PAIRS = 4;

	// Offset range and the stages of the offset divide pipeline after issue.
	localparam int OFS_MAX   = 4095;
	localparam int DIV_DEPTH = 2;

	// Reciprocal shift: exact for 20-bit magnitudes and divisors up to 2**FRAME_W.
	localparam int DIV_SHIFT = SUM_W + FRAME_W;

	// Per-beat update strobes from the calibration control to the lanes.
	typedef struct packed {
		logic acc;
		logic clear;
	} ipdc_upd_t;

	// Offset divide request from the sequencer to the lanes.
	typedef struct packed {
		logic              issue;
		logic [PAIR_W-1:0] idx;
	} ipdc_div_t;

	// One result beat as held in the output buffer.
	typedef struct packed {
		logic [PAIR_W-1:0]         pair_echo;
		logic signed [DELTA_W-1:0] delta_first;
		logic signed [DELTA_W-1:0] delta_second;
		logic [CAL_W-1:0]          calibrated_first;
		logic [CAL_W-1:0]          calibrated_second;
		logic                      calibrating;
	} ipdc_beat_t;

endpackage
`default_nettype wire

### sv/ipdc_in_if.sv
// Input channel carrying one sampled sensor pair per beat.
`default_nettype none
interface ipdc_in_if;
	logic                          valid;
	logic                          ready;
	logic [ipdc_pkg::PAIR_W-1:0]   pair_index;
	logic [ipdc_pkg::SAMPLE_W-1:0] ambient_first;
	logic [ipdc_pkg::SAMPLE_W-1:0] ambient_second;
	logic [ipdc_pkg::SAMPLE_W-1:0] reflected_first;
	logic [ipdc_pkg::SAMPLE_W-1:0] reflected_second;
	logic                          start_calibration;

	modport source (
		output valid, pair_index, ambient_first, ambient_second,
		output reflected_first, reflected_second, start_calibration,
		input  ready
	);

	modport sink (
		input  valid, pair_index, ambient_first, ambient_second,
		input  reflected_first, reflected_second, start_calibration,
		output ready
	);
endinterface
`default_nettype wire

### sv/ipdc_out_if.sv
// Output channel carrying the deltas and calibrated values of one pair per beat.
`default_nettype none
interface ipdc_out_if;
	logic                                valid;
	logic                                ready;
	logic [ipdc_pkg::PAIR_W-1:0]         pair_echo;
	logic signed [ipdc_pkg::DELTA_W-1:0] delta_first;
	logic signed [ipdc_pkg::DELTA_W-1:0] delta_second;
	logic [ipdc_pkg::CAL_W-1:0]          calibrated_first;
	logic [ipdc_pkg::CAL_W-1:0]          calibrated_second;
	logic                                calibrating;

	modport source (
		output valid, pair_echo, delta_first, delta_second,
		output calibrated_first, calibrated_second, calibrating,
		input  ready
	);

	modport sink (
		input  valid, pair_echo, delta_first, delta_second,
		input  calibrated_first, calibrated_second, calibrating,
		output ready
	);
endinterface
`default_nettype wire

### sv/ipdc_lane.sv
// One sensor lane: delta, calibrated value, sum bank, offset bank and offset divider.
`default_nettype none
module ipdc_lane #(
	parameter int PAIRS       = 4,
	parameter int CAL_FRAMES  = 100,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ipdc_pkg::SAMPLE_W-1:0]       ambient,
	input  wire logic [ipdc_pkg::SAMPLE_W-1:0]       reflected,
	input  wire logic [ipdc_pkg::PAIR_W-1:0]         pair_index,
	input  wire logic                                hit,
	input  wire ipdc_pkg::ipdc_upd_t                 upd,
	input  wire ipdc_pkg::ipdc_div_t                 div,
	output logic signed [ipdc_pkg::DELTA_W-1:0]      delta,
	output logic [ipdc_pkg::CAL_W-1:0]               calibrated
);
	import ipdc_pkg::*;

	localparam int IDX_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << EFF_BITS) - 1);

	// Reciprocal of the frame count, rounded up, for an exact truncating divide.
	localparam int RECIP_W = DIV_SHIFT + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - DIV_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / CAL_FRAMES + 1);
	localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(OFS_MAX);
	localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(OFS_MAX + 1);

	logic signed [OFS_W-1:0] offs_q [PAIRS];
	logic signed [SUM_W-1:0] sums_q [PAIRS];

	logic [IDX_W-1:0]          rd_idx;
	logic signed [OFS_W-1:0]   ofs;
	logic signed [DELTA_W:0]   diff;
	logic signed [SUM_W:0]     sum_ext;
	logic signed [SUM_W-1:0]   sum_sat;

	logic [IDX_W-1:0]          div_idx;
	logic signed [SUM_W-1:0]   div_sum;
	logic [SUM_W-1:0]          div_mag;

	logic                      v_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      neg_s1;
	logic [SUM_W-1:0]          mag_s1;
	logic                      v_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic                      neg_s2;
	logic [PROD_W-1:0]         prod_s2;

	logic [QUOT_W-1:0]         quot;
	logic signed [OFS_W-1:0]   ofs_new;

	// Delta of the masked samples and the calibrated value against the stored offset.
	assign rd_idx = IDX_W'(pair_index);
	assign delta  = DELTA_W'($signed({1'b0, ambient & SAMPLE_MASK}))
		- DELTA_W'($signed({1'b0, reflected & SAMPLE_MASK}));
	assign ofs    = hit ? offs_q[rd_idx] : '0;
	assign diff   = {delta[DELTA_W-1], delta} - {ofs[OFS_W-1], ofs};
	assign calibrated = diff[DELTA_W] ? '0 : CAL_W'(diff[DELTA_W-1:0]);

	// Saturating add of the delta into the selected sum.
	always_comb begin
		sum_ext = {sums_q[rd_idx][SUM_W-1], sums_q[rd_idx]} + (SUM_W + 1)'(delta);
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	// Divide issue: magnitude and sign of the selected sum.
	assign div_idx = IDX_W'(div.idx);
	assign div_sum = sums_q[div_idx];
	assign div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);

	// Divide pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= div.issue;
			v_s2 <= v_s1;
		end
	end

	// Divide pipeline payload: magnitude, then product with the reciprocal.
	always_ff @(posedge clk) begin
		idx_s1  <= div_idx;
		neg_s1  <= div_sum[SUM_W-1];
		mag_s1  <= div_mag;
		idx_s2  <= idx_s1;
		neg_s2  <= neg_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(RECIP);
	end

	// Quotient truncated toward zero, restored in sign and clamped to the offset range.
	always_comb begin
		quot = prod_s2[PROD_W-1:DIV_SHIFT];
		if (neg_s2) begin
			ofs_new = (quot > NEG_LIMIT) ? OFS_W'(-(OFS_MAX + 1)) : -OFS_W'(quot);
		end else begin
			ofs_new = (quot > POS_LIMIT) ? OFS_W'(OFS_MAX) : OFS_W'(quot);
		end
	end

	// Sum and offset banks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAIRS; i++) begin
				offs_q[i] <= '0;
				sums_q[i] <= '0;
			end
		end else if (upd.clear) begin
			for (int i = 0; i < PAIRS; i++) begin
				offs_q[i] <= '0;
				sums_q[i] <= '0;
			end
		end else begin
			if (upd.acc) begin
				sums_q[rd_idx] <= sum_sat;
			end
			if (v_s2) begin
				offs_q[idx_s2] <= ofs_new;
			end
		end
	end

endmodule
`default_nettype wire

### sv/ipdc_merge.sv
// Merges the two lane results into a beat and buffers two beats toward the output.
`default_nettype none
module ipdc_merge (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic [ipdc_pkg::PAIR_W-1:0]        pair_index,
	input  wire logic signed [ipdc_pkg::DELTA_W-1:0] delta_first,
	input  wire logic signed [ipdc_pkg::DELTA_W-1:0] delta_second,
	input  wire logic [ipdc_pkg::CAL_W-1:0]         calibrated_first,
	input  wire logic [ipdc_pkg::CAL_W-1:0]         calibrated_second,
	input  wire logic                               calibrating,
	output logic                                    ready,
	ipdc_out_if.source                              report
);
	import ipdc_pkg::*;

	ipdc_beat_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	ipdc_beat_t beat;
	ipdc_beat_t head;

	assign beat = '{
		pair_echo:         pair_index,
		delta_first:       delta_first,
		delta_second:      delta_second,
		calibrated_first:  calibrated_first,
		calibrated_second: calibrated_second,
		calibrating:       calibrating
	};

	assign ready = (count_q != 2'd2);
	assign pop   = report.valid && report.ready;

	// Buffer storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= beat;
		end
	end

	// Buffer pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Head beat toward the output channel.
	assign head                     = ent_q[rd_ptr_q];
	assign report.valid             = (count_q != 2'd0);
	assign report.pair_echo         = head.pair_echo;
	assign report.delta_first       = head.delta_first;
	assign report.delta_second      = head.delta_second;
	assign report.calibrated_first  = head.calibrated_first;
	assign report.calibrated_second = head.calibrated_second;
	assign report.calibrating       = head.calibrating;

endmodule
`default_nettype wire

### sv/ir_proximity_delta_calibrator.sv
// Each accepted input beat is registered as a result beat into the output buffer.
// One pair per cycle unless output is full or offsets are being written; a two-beat
// output buffer absorbs output stalls. The beat that completes calibration stops input
// while each lane's reciprocal multiplier pipeline writes its offsets one pair a cycle.
// Reset clears offsets, sums, frame count, calibration flags and the output buffer.
`default_nettype none
module ir_proximity_delta_calibrator #(
	parameter int SENSOR_COUNT = ipdc_pkg::SENSOR_COUNT_DEF,
	parameter int CAL_FRAMES   = ipdc_pkg::CAL_FRAMES_DEF,
	parameter int SAMPLE_BITS  = ipdc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ipdc_in_if.sink    pair,
	ipdc_out_if.source report
);
	import ipdc_pkg::*;

	localparam int HALF  = SENSOR_COUNT / 2;
	localparam int PAIRS = (HALF < MAX_PAIRS) ? HALF : MAX_PAIRS;
	localparam int RUN_LEN = PAIRS + DIV_DEPTH;
	localparam int CNT_W = $clog2(RUN_LEN);
	localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);
	localparam logic [PAIR_W:0]   PAIRS_V   = (PAIR_W + 1)'(PAIRS);
	localparam logic [CNT_W-1:0]  ISSUE_END = CNT_W'(PAIRS);
	localparam logic [CNT_W-1:0]  RUN_END   = CNT_W'(RUN_LEN - 1);
	localparam logic [FRAME_W-1:0] FRAMES_V = FRAME_W'(CAL_FRAMES);

	logic               active_q;
	logic               accum_q;
	logic [FRAME_W-1:0] frame_q;
	logic               run_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               fifo_ready;
	logic               accept;
	logic               hit;
	logic               eff_active;
	logic               eff_accum;
	logic               frame_end;
	logic [FRAME_W-1:0] frame_next;
	logic               finish;
	logic               active_after;
	ipdc_upd_t          upd;
	ipdc_div_t          div;

	logic signed [DELTA_W-1:0] delta_first;
	logic signed [DELTA_W-1:0] delta_second;
	logic [CAL_W-1:0]          cal_first;
	logic [CAL_W-1:0]          cal_second;

	// Input handshake: held off while offsets are being written.
	assign pair.ready = fifo_ready && !run_q;
	assign accept     = pair.valid && pair.ready;

	// Calibration control for the current beat; the start flag applies first.
	assign hit          = {1'b0, pair.pair_index} < PAIRS_V;
	assign eff_active   = pair.start_calibration || active_q;
	assign eff_accum    = !pair.start_calibration && accum_q;
	assign frame_end    = hit && (pair.pair_index == LAST_PAIR) && eff_active;
	assign frame_next   = frame_q + FRAME_W'(1);
	assign finish       = frame_end && eff_accum && (frame_next == FRAMES_V);
	assign active_after = eff_active && !finish;

	assign upd.acc   = accept && hit && eff_active && eff_accum;
	assign upd.clear = accept && frame_end && !eff_accum;

	// Offset divide sequencer: one pair per cycle, then the pipeline drains.
	assign div.issue = run_q && (cnt_q < ISSUE_END);
	assign div.idx   = PAIR_W'(cnt_q);

	// Calibration state and divide sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			accum_q  <= 1'b0;
			frame_q  <= '0;
			run_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				active_q <= active_after;
				if (frame_end && !eff_accum) begin
					accum_q <= 1'b1;
					frame_q <= '0;
				end else if (frame_end) begin
					accum_q <= !finish;
					frame_q <= frame_next;
				end else begin
					accum_q <= eff_accum;
				end
			end
			if (accept && finish) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == RUN_END) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Lane for sensor k.
	ipdc_lane #(
		.PAIRS       (PAIRS),
		.CAL_FRAMES  (CAL_FRAMES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_first (
		.clk        (clk),
		.arst_n     (arst_n),
		.ambient    (pair.ambient_first),
		.reflected  (pair.reflected_first),
		.pair_index (pair.pair_index),
		.hit        (hit),
		.upd        (upd),
		.div        (div),
		.delta      (delta_first),
		.calibrated (cal_first)
	);

	// Lane for sensor k + SENSOR_COUNT / 2.
	ipdc_lane #(
		.PAIRS       (PAIRS),
		.CAL_FRAMES  (CAL_FRAMES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_second (
		.clk        (clk),
		.arst_n     (arst_n),
		.ambient    (pair.ambient_second),
		.reflected  (pair.reflected_second),
		.pair_index (pair.pair_index),
		.hit        (hit),
		.upd        (upd),
		.div        (div),
		.delta      (delta_second),
		.calibrated (cal_second)
	);

	// Result beat assembly and output buffer.
	ipdc_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (accept),
		.pair_index        (pair.pair_index),
		.delta_first       (delta_first),
		.delta_second      (delta_second),
		.calibrated_first  (cal_first),
		.calibrated_second (cal_second),
		.calibrating       (active_after),
		.ready             (fifo_ready),
		.report            (report)
	);

endmodule
`default_nettype wire
